FILE: hdl/bfbp_pkg.sv
// shared types and constants of the best-fit bin packer
// no dependencies
package bfbp_pkg;

    localparam int MAX_BINS_DEF    = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int FIELD_W   = 16;
    localparam int BIN_IDX_W = 6;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 2;

    localparam logic [FIELD_W-1:0] CAP_RESET = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_BIN_CAPACITY = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_EXISTING = 2'd0,
        ST_NEW      = 2'd1,
        ST_FULL     = 2'd2,
        ST_HEAVY    = 2'd3
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] weight;
        logic [FIELD_W-1:0] item_id;
        logic               start_packing;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]   placed_id;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [FIELD_W-1:0]   load_after;
        status_t              status;
    } result_t;

endpackage

FILE: hdl/best_fit_bin_packer.sv
// best-fit bin packer top level: apb register, sequencer, load ram, compare unit
// depends on bfbp_pkg, bfbp_ram, bfbp_scan
//
// An item is taken when start is high and busy is low. Unless the item is too
// heavy, the sequencer then reads the load of every open bin from the load ram,
// one bin a cycle, through a single compare unit, and writes the chosen load back.
// The time from acceptance to the next possible acceptance grows with the number
// of open bins, set by the one-read-per-cycle ram port; a too-heavy item skips
// the scan. The result sits on result for one cycle with done high and cannot be
// stalled; the next item may be accepted in that same cycle. Configuration writes
// are only legal while busy is low.
module best_fit_bin_packer #(
    parameter int MAX_BINS    = bfbp_pkg::MAX_BINS_DEF,
    parameter int WEIGHT_BITS = bfbp_pkg::WEIGHT_BITS_DEF,
    parameter int ID_BITS     = bfbp_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfbp_pkg::APB_AW-1:0]   paddr,
    input  logic [bfbp_pkg::APB_DW-1:0]   pwdata,
    output logic [bfbp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  bfbp_pkg::item_t               item,
    output logic                          done,
    output bfbp_pkg::result_t             result
);

    localparam int FW   = bfbp_pkg::FIELD_W;
    localparam int AW   = bfbp_pkg::APB_AW;
    localparam int IDXW = $clog2(MAX_BINS);
    localparam int CNTW = $clog2(MAX_BINS + 1);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_BINS);
    localparam logic [AW-1:0] CAP_ADDR = AW'(4 * int'(bfbp_pkg::REG_BIN_CAPACITY));
    localparam logic [FW-1:0] WMASK =
        (WEIGHT_BITS >= FW) ? {FW{1'b1}} : FW'((33'd1 << WEIGHT_BITS) - 33'd1);
    localparam logic [FW-1:0] IMASK =
        (ID_BITS >= FW) ? {FW{1'b1}} : FW'((33'd1 << ID_BITS) - 33'd1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [FW-1:0]        cap_reg;
    logic [CNTW-1:0]      count_reg;
    logic [CNTW-1:0]      count_next;
    logic [CNTW-1:0]      issue_reg;
    logic [CNTW-1:0]      issue_next;
    logic                 pend_vld_reg;
    logic                 pend_vld_next;
    logic [IDXW-1:0]      pend_idx_reg;
    logic [FW-1:0]        weight_reg;
    logic [FW-1:0]        id_reg;
    logic [FW-1:0]        room_reg;
    logic                 heavy_reg;
    logic                 done_reg;
    logic                 done_next;
    bfbp_pkg::result_t    result_reg;
    bfbp_pkg::result_t    result_next;

    logic                 accept;
    logic                 cfg_wr;
    logic [FW-1:0]        in_weight;
    logic                 issue_more;
    logic                 ram_we;
    logic [IDXW-1:0]      ram_waddr;
    logic [FW-1:0]        ram_wdata;
    logic [FW-1:0]        ram_rdata;
    logic                 scan_found;
    logic [IDXW-1:0]      scan_idx;
    logic [FW-1:0]        scan_load;
    logic [31:0]          idx_wide;
    logic [31:0]          cnt_wide;
    logic [FW-1:0]        sum_load;

    // apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == CAP_ADDR);
    assign prdata = {{(bfbp_pkg::APB_DW - FW){1'b0}}, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= bfbp_pkg::CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[FW-1:0];
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign in_weight  = item.weight & WMASK;
    assign issue_more = (issue_reg < count_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_vld_next = 1'b0;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_we        = 1'b0;
        ram_waddr     = scan_idx;
        ram_wdata     = sum_load;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    issue_next = '0;
                    if (item.start_packing)
                    begin
                        count_next = '0;
                    end
                    if (in_weight > cap_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_more)
                begin
                    issue_next    = issue_reg + 1'b1;
                    pend_vld_next = 1'b1;
                end
                else if (!pend_vld_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next            = S_IDLE;
                done_next             = 1'b1;
                result_next.placed_id = id_reg;
                result_next.bin_index = '0;
                result_next.load_after = '0;
                if (heavy_reg)
                begin
                    result_next.status = bfbp_pkg::ST_HEAVY;
                end
                else if (scan_found)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = scan_idx;
                    ram_wdata              = sum_load;
                    result_next.bin_index  = idx_wide[bfbp_pkg::BIN_IDX_W-1:0];
                    result_next.load_after = sum_load;
                    result_next.status     = bfbp_pkg::ST_EXISTING;
                end
                else if (count_reg < CNT_MAX)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = count_reg[IDXW-1:0];
                    ram_wdata              = weight_reg;
                    count_next             = count_reg + 1'b1;
                    result_next.bin_index  = cnt_wide[bfbp_pkg::BIN_IDX_W-1:0];
                    result_next.load_after = weight_reg;
                    result_next.status     = bfbp_pkg::ST_NEW;
                end
                else
                begin
                    result_next.status = bfbp_pkg::ST_FULL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign sum_load = scan_load + weight_reg;
    assign idx_wide = 32'(scan_idx);
    assign cnt_wide = 32'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            pend_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            pend_vld_reg <= pend_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg   <= result_next;
        pend_idx_reg <= issue_reg[IDXW-1:0];
        if (accept)
        begin
            weight_reg <= in_weight;
            id_reg     <= item.item_id & IMASK;
            heavy_reg  <= (in_weight > cap_reg);
            room_reg   <= cap_reg - in_weight;
        end
    end

    bfbp_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_BINS)
    ) u_loads (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[IDXW-1:0]),
        .rdata (ram_rdata)
    );

    bfbp_scan #(
        .MAX_BINS (MAX_BINS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .load_vld  (pend_vld_reg),
        .load_idx  (pend_idx_reg),
        .load_val  (ram_rdata),
        .room      (room_reg),
        .found     (scan_found),
        .best_idx  (scan_idx),
        .best_load (scan_load)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/bfbp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bfbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bfbp_scan.sv
// best-fit compare unit: keeps the fullest bin seen so far that still has room
// depends on bfbp_pkg
module bfbp_scan #(
    parameter int MAX_BINS = bfbp_pkg::MAX_BINS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                load_vld,
    input  logic [$clog2(MAX_BINS)-1:0]         load_idx,
    input  logic [bfbp_pkg::FIELD_W-1:0]        load_val,
    input  logic [bfbp_pkg::FIELD_W-1:0]        room,
    output logic                                found,
    output logic [$clog2(MAX_BINS)-1:0]         best_idx,
    output logic [bfbp_pkg::FIELD_W-1:0]        best_load
);

    localparam int IDXW = $clog2(MAX_BINS);

    logic                          found_reg;
    logic                          found_next;
    logic [IDXW-1:0]               best_idx_reg;
    logic [IDXW-1:0]               best_idx_next;
    logic [bfbp_pkg::FIELD_W-1:0]  best_load_reg;
    logic [bfbp_pkg::FIELD_W-1:0]  best_load_next;
    logic                          better;

    // fits, and strictly fuller so the lowest index wins ties
    assign better = (load_val <= room) && (!found_reg || (load_val > best_load_reg));

    always_comb
    begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_load_next = best_load_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (load_vld && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = load_idx;
            best_load_next = load_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_load_reg <= best_load_next;
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_load = best_load_reg;

endmodule
